[design/itsc_pkg.sv]
// Package for the icon tile slot cache: request codes, the free-slot mark
// and the command struct between controller and datapath. No dependencies.
package itsc_pkg;

  localparam int IconW = 16;
  localparam int FuncW = 2;
  localparam int BaseW = 10;
  localparam int TileW = 16;

  localparam logic [IconW-1:0] FREE_MARK = 16'hFFFF;
  localparam logic [BaseW-1:0] BASE_RESET = 10'd1023;

  localparam logic [FuncW-1:0] FUNC_GET       = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CLEAR_ONE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CLEAR_ALL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Take the request fields into the datapath.
    logic match;    // Compare every slot against the captured icon.
    logic commit;   // Update the table and load the result register.
  } itsc_cmd_t;

endpackage

[design/itsc_ctrl.sv]
// Controller of the icon tile slot cache: sequences capture, match and
// commit for each request and owns the output valid flag. Uses itsc_pkg.
module itsc_ctrl
  import itsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output itsc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // The result register may be reloaded once its current request is gone.
  assign commit      = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.match   = (state_q == ST_MATCH);
    cmd_o.commit  = commit;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_accept_to_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MATCH))
    else $error("accepted request did not move to the match step");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("commit did not present a result");

endmodule

[design/itsc_datapath.sv]
// Datapath of the icon tile slot cache: slot table with valid bits,
// parallel compare, first-match and first-free encoders, result register.
// Uses itsc_pkg.
module itsc_datapath
  import itsc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itsc_cmd_t        cmd_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [IconW-1:0] icon_i,
  input  logic             cfg_we_i,
  input  logic [BaseW-1:0] cfg_wdata_i,
  output logic [TileW-1:0] tile_o,
  output logic             hit_o,
  output logic             needs_load_o,
  output logic             full_res_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NumW = $clog2(SLOTS + 1);

  logic [FuncW-1:0] func_q;
  logic [IconW-1:0] icon_q;
  logic [BaseW-1:0] base_q;
  logic [IconW-1:0] icon_tab_q [SLOTS];
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] match_q, match_d;
  logic [SLOTS-1:0] free_q, free_d;

  logic [TileW-1:0] tile_q, tile_d;
  logic             hit_q, hit_d;
  logic             load_q, load_d;
  logic             full_q, full_d;

  logic [IdxW-1:0]  hit_idx, free_idx;
  logic             any_hit, any_free;
  logic             reserved;
  logic             alloc;
  logic [NumW-1:0]  hit_num, free_num;
  logic [TileW-1:0] hit_tile, free_tile, base_tile;

  // Parallel compare, registered before the encoders.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_d[i] = valid_q[i] && (icon_tab_q[i] == icon_q);
      free_d[i]  = !valid_q[i];
    end
  end

  // Lowest set bit wins in both encoders.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IdxW'(i);
      if (free_q[i]) free_idx = IdxW'(i);
    end
  end

  assign any_hit  = |match_q;
  assign any_free = |free_q;
  assign reserved = (icon_q == FREE_MARK);

  // Tile of 1-based slot s is base minus four times s, modulo 2^16.
  assign hit_num   = NumW'(hit_idx) + NumW'(1);
  assign free_num  = NumW'(free_idx) + NumW'(1);
  assign base_tile = TileW'(base_q);
  assign hit_tile  = base_tile - TileW'({hit_num, 2'b00});
  assign free_tile = base_tile - TileW'({free_num, 2'b00});

  always_comb begin
    tile_d  = '0;
    hit_d   = 1'b0;
    load_d  = 1'b0;
    full_d  = 1'b0;
    alloc   = 1'b0;
    valid_d = valid_q;
    unique case (func_q)
      FUNC_GET: begin
        if (reserved) begin
          tile_d = base_tile;
        end else if (any_hit) begin
          hit_d  = 1'b1;
          tile_d = hit_tile;
        end else if (any_free) begin
          load_d            = 1'b1;
          alloc             = 1'b1;
          tile_d            = free_tile;
          valid_d[free_idx] = 1'b1;
        end else begin
          full_d = 1'b1;
          tile_d = base_tile;
        end
      end
      FUNC_CLEAR_ONE: begin
        if (!reserved && any_hit) begin
          hit_d            = 1'b1;
          valid_d[hit_idx] = 1'b0;
        end
      end
      FUNC_CLEAR_ALL: begin
        valid_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      base_q  <= BASE_RESET;
    end else begin
      if (cmd_i.commit) valid_q <= valid_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      icon_q <= icon_i;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
      free_q  <= free_d;
    end
    if (cmd_i.commit) begin
      tile_q <= tile_d;
      hit_q  <= hit_d;
      load_q <= load_d;
      full_q <= full_d;
      if (alloc) icon_tab_q[free_idx] <= icon_q;
    end
  end

  assign tile_o       = tile_q;
  assign hit_o        = hit_q;
  assign needs_load_o = load_q;
  assign full_res_o   = full_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> $onehot0({hit_q, load_q, full_q}))
    else $error("more than one result flag set");

  a_hit_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && any_hit) |-> valid_q[hit_idx])
    else $error("matched slot is not in use");

  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && alloc) |=> valid_q[$past(free_idx)])
    else $error("allocated slot not marked in use");

endmodule

[design/icon_tile_slot_cache_core.sv]
// Icon tile slot cache, top level: joins the controller and the datapath.
// Uses itsc_pkg, itsc_ctrl and itsc_datapath.
//
// Usage: each request on the input channel (func_i, icon_i) carries a get,
// a clear-one or a clear-all, and produces exactly one result request on
// the output channel (tile_o, hit_o, needs_load_o, full_res_o). A get that
// hits returns the tile of the first matching slot; a miss stores the icon
// in the first free slot and raises needs_load_o; a miss with no free slot
// raises full_res_o; it and a get of the free mark return the base tile.
// Timing: an accepted request passes a match step, which registers its
// compare against all slots, and a commit step, which loads the output
// register and raises out_valid_o. in_ready_o returns at that edge; no new
// request is taken while one is in its match or commit step. The compare
// and encode steps of the slot table each have a register after them.
// When the receiver stalls, the result stays in the output register; a new
// request can still be taken and compared, and it commits as soon as the
// previous result has been taken.
// Reset clears every slot valid bit at once (no clearing pass), sets the
// tile base to 1023 and empties the output register. The user writes the
// base via cfg_we_i/cfg_wdata_i with no request in flight; not enforced.
module icon_tile_slot_cache_core
  import itsc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [IconW-1:0] icon_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TileW-1:0] tile_o,
  output logic             hit_o,
  output logic             needs_load_o,
  output logic             full_res_o,
  input  logic             cfg_we_i,
  input  logic [BaseW-1:0] cfg_wdata_i
);

  itsc_cmd_t cmd;

  // The controller only sequences; all table state lives in the datapath.
  itsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  itsc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (func_i),
    .icon_i       (icon_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tile_o       (tile_o),
    .hit_o        (hit_o),
    .needs_load_o (needs_load_o),
    .full_res_o   (full_res_o)
  );

endmodule

[tb/icon_tile_slot_cache_core_tb.sv]
// Self-checking testbench for icon_tile_slot_cache_core: random and directed
// get/clear requests are checked against a slot table model kept in the bench.
// Depends on itsc_pkg and the icon_tile_slot_cache_core RTL.
module icon_tile_slot_cache_core_tb;
  import itsc_pkg::*;

  localparam int SLOTS = 32;

  // The fourth function code is not decoded by the block. It must be
  // accepted and answered with an all-zero result.
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  // Cycles without any handshake before the run is declared hung. The
  // longest legal quiet stretch is the forced receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 400;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int POOL_SIZE      = 48;
  // Slack given after the last result before the next register write.
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IconW-1:0] icon;
  } icon_req_t;

  typedef struct packed {
    logic [TileW-1:0] tile;
    logic             hit;
    logic             needs_load;
    logic             full_res;
  } tile_answer_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [FuncW-1:0] func_i       = '0;
  logic [IconW-1:0] icon_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [TileW-1:0] tile_o;
  logic             hit_o;
  logic             needs_load_o;
  logic             full_res_o;
  logic             cfg_we_i     = 1'b0;
  logic [BaseW-1:0] cfg_wdata_i  = '0;

  // Requests waiting to be offered, and answers waiting for their result.
  icon_req_t    icon_reqs_q[$];
  tile_answer_t tile_answers_q[$];

  // Model of the block: slot contents and the tile base register.
  logic [IconW-1:0] slot_icon_model [SLOTS];
  logic [BaseW-1:0] base_model = BASE_RESET;

  logic [IconW-1:0] icon_pool [POOL_SIZE];

  int unsigned accepted_reqs  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned hold_left      = 0;

  icon_tile_slot_cache_core #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .icon_i      (icon_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tile_o      (tile_o),
    .hit_o       (hit_o),
    .needs_load_o(needs_load_o),
    .full_res_o  (full_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // After reset every slot is free.
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_icon_model[i] = FREE_MARK;
    end
  end

  // Tile of 1-based slot number s: the base counts down four tiles per
  // slot, wrapping modulo 2^16 when the base is small.
  function automatic logic [TileW-1:0] slot_tile(input int s);
    logic [TileW-1:0] base_wide;
    base_wide = {{(TileW-BaseW){1'b0}}, base_model};
    return base_wide - TileW'(4 * s);
  endfunction

  // Applies one request to the slot table model and returns the answer the
  // block must give. The first matching slot wins, for both the icon search
  // and the free-slot search.
  task automatic lookup_icon(input icon_req_t req, output tile_answer_t ans);
    int hit_slot;
    int free_slot;
    hit_slot  = 0;
    free_slot = 0;
    ans       = '0;
    for (int s = 1; s <= SLOTS; s++) begin
      if (hit_slot == 0 && slot_icon_model[s-1] == req.icon) hit_slot = s;
      if (free_slot == 0 && slot_icon_model[s-1] == FREE_MARK) free_slot = s;
    end
    case (req.func)
      FUNC_GET: begin
        if (req.icon == FREE_MARK) begin
          // The free mark itself never matches and never allocates.
          ans.tile = {{(TileW-BaseW){1'b0}}, base_model};
        end else if (hit_slot != 0) begin
          ans.hit  = 1'b1;
          ans.tile = slot_tile(hit_slot);
        end else if (free_slot != 0) begin
          slot_icon_model[free_slot-1] = req.icon;
          ans.needs_load = 1'b1;
          ans.tile       = slot_tile(free_slot);
        end else begin
          // Table full: report it and hand back the base tile.
          ans.full_res = 1'b1;
          ans.tile     = {{(TileW-BaseW){1'b0}}, base_model};
        end
      end
      FUNC_CLEAR_ONE: begin
        if (req.icon != FREE_MARK && hit_slot != 0) begin
          slot_icon_model[hit_slot-1] = FREE_MARK;
          ans.hit = 1'b1;
        end
      end
      FUNC_CLEAR_ALL: begin
        for (int s = 0; s < SLOTS; s++) begin
          slot_icon_model[s] = FREE_MARK;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [TileW-1:0] got,
                                 input logic [TileW-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Request driver. The prediction is taken at the edge where the request
  // is accepted, so the model sees requests in the same order as the block.
  // Between about 700 and 1000 accepted requests the sender never idles with
  // requests queued, keeping the block running back to back for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    icon_req_t    nxt;
    tile_answer_t ans;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i     <= '0;
      icon_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lookup_icon('{func: func_i, icon: icon_i}, ans);
        tile_answers_q.push_back(ans);
        accepted_reqs++;
      end
      // A request still waiting for ready keeps valid and payload as is.
      if (!in_valid_i || in_ready_o) begin
        if (icon_reqs_q.size() != 0 &&
            ((accepted_reqs >= 700 && accepted_reqs < 1000) ||
             $urandom_range(99, 0) >= 6)) begin
          nxt = icon_reqs_q.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= nxt.func;
          icon_i     <= nxt.icon;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted result is compared with the oldest
  // answer waiting. Once, after a few hundred results, the receiver holds
  // ready low for a long stretch while the driver keeps offering requests,
  // so the output register and the compare stage fill and input stalls.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    tile_answer_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (tile_answers_q.size() == 0) begin
          report_mismatch("unexpected result tile", tile_o, '0);
        end else begin
          want = tile_answers_q.pop_front();
          if (tile_o !== want.tile) report_mismatch("tile", tile_o, want.tile);
          if (hit_o !== want.hit) begin
            report_mismatch("hit", TileW'(hit_o), TileW'(want.hit));
          end
          if (needs_load_o !== want.needs_load) begin
            report_mismatch("needs_load", TileW'(needs_load_o), TileW'(want.needs_load));
          end
          if (full_res_o !== want.full_res) begin
            report_mismatch("full_res", TileW'(full_res_o), TileW'(want.full_res));
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (results_seen >= 700 && results_seen < 1000) ||
                       ($urandom_range(99, 0) >= 6);
      end
    end
  end

  // Hang detection: any handshake on either channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("** icon_tile_slot_cache_core: FAILED **");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic [FuncW-1:0] func, input logic [IconW-1:0] icon);
    icon_reqs_q.push_back('{func: func, icon: icon});
  endtask

  // Waits until every queued request has gone in and every result has come
  // out, then lets the pipeline settle. This is also the point where the
  // sender pauses until the block has gone completely quiet.
  task automatic drain_block();
    @(negedge clk_i);
    while (icon_reqs_q.size() != 0 || in_valid_i || tile_answers_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the tile base while the block is idle and mirrors it in the model.
  task automatic write_tile_base(input logic [BaseW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_model = value;
    @(negedge clk_i);
  endtask

  // Random requests are mostly gets and clears of icons from a small pool,
  // larger than the table, so hits, reuse of freed slots and a full table
  // all happen often. The rest are the free mark and fully random icons.
  task automatic push_random_req();
    int unsigned      pick;
    logic [FuncW-1:0] func;
    logic [IconW-1:0] icon;
    pick = $urandom_range(99, 0);
    if (pick < 75) func = FUNC_GET;
    else if (pick < 97) func = FUNC_CLEAR_ONE;
    else if (pick < 98) func = FUNC_CLEAR_ALL;
    else func = FUNC_UNUSED;
    pick = $urandom_range(99, 0);
    if (pick < 85) icon = icon_pool[$urandom_range(POOL_SIZE-1, 0)];
    else if (pick < 90) icon = FREE_MARK;
    else icon = IconW'($urandom_range(65535, 0));
    push_req(func, icon);
  endtask

  initial begin : stimulus
    logic [BaseW-1:0] bases [5];
    bases[0] = '0;
    bases[1] = 10'd1023;
    bases[2] = 10'd128;
    bases[3] = BaseW'($urandom_range(1023, 0));
    bases[4] = BaseW'($urandom_range(1023, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests at the reset base: allocation of the first slot, a
    // hit on it, the largest legal icon, the free mark on get and on clear,
    // clearing a present and an absent icon, reuse of the freed first slot,
    // the undecoded function code, clear-all, and allocation after it.
    push_req(FUNC_GET,       16'h0000);
    push_req(FUNC_GET,       16'h0000);
    push_req(FUNC_GET,       16'hFFFE);
    push_req(FUNC_GET,       FREE_MARK);
    push_req(FUNC_CLEAR_ONE, FREE_MARK);
    push_req(FUNC_CLEAR_ONE, 16'h0000);
    push_req(FUNC_CLEAR_ONE, 16'h0000);
    push_req(FUNC_GET,       16'h5A5A);
    push_req(FUNC_UNUSED,    16'hA5A5);
    push_req(FUNC_CLEAR_ALL, 16'h0000);
    push_req(FUNC_GET,       16'hFFFE);
    push_req(FUNC_CLEAR_ONE, 16'h8001);
    drain_block();

    // Random phases, each at its own tile base: zero (tiles wrap below
    // zero), the largest base, and a few others.
    foreach (bases[p]) begin
      write_tile_base(bases[p]);
      foreach (icon_pool[i]) begin
        icon_pool[i] = IconW'($urandom_range(65534, 0));
      end
      repeat (ITEMS_PER_PHASE) push_random_req();
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("** icon_tile_slot_cache_core: PASSED **");
    end else begin
      $display("** icon_tile_slot_cache_core: FAILED **");
    end
    $finish;
  end

endmodule
